>>> rtl/rsrc_pkg.sv
// shared types, codes and default sizes for the region shift/rotate canvas
// no dependencies; imported by rsrc_ctrl, rsrc_datapath and the top level
package rsrc_pkg;

   localparam int DEF_CANVAS_WIDTH  = 64;
   localparam int DEF_CANVAS_HEIGHT = 64;
   localparam int DEF_PIXEL_BITS    = 8;

   // fixed port widths
   localparam int CMD_W    = 2;
   localparam int POS_W    = 6;
   localparam int SIZE_W   = 7;
   localparam int DIR_W    = 2;
   localparam int PORT_PIX_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_MOVE  = 2'd2
   } cmd_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic pix_write;
      logic pix_read;
      logic line_start;
      logic scan_step;
      logic tail;
      logic wrap_write;
      logic next_line;
      logic rsp_load;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_write;
      logic is_read;
      logic move_go;
      logic wrap;
      logic line_last;
      logic lines_last;
   } dp_status_type;

endpackage

>>> rtl/rsrc_ctrl.sv
// controller state machine for the region shift/rotate canvas
// depends on rsrc_pkg; drives the datapath through ctrl_cmd_type
module rsrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsrc_pkg::dp_status_type status_i,
   output rsrc_pkg::ctrl_cmd_type  cmd_o
);
   import rsrc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_TAIL,
      ST_WRAP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd_o    = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd_o.pix_write = status_i.is_write;
            cmd_o.pix_read  = status_i.is_read;
            if (status_i.move_go) begin
               cmd_o.line_start = 1'b1;
               state_in         = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd_o.scan_step = 1'b1;
            if (status_i.line_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            cmd_o.tail = 1'b1;
            priority if (status_i.wrap) begin
               state_in = ST_WRAP;
            end else if (status_i.lines_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd_o.next_line = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_WRAP: begin
            cmd_o.wrap_write = 1'b1;
            if (status_i.lines_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd_o.next_line = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_FINISH: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_o.rsp_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd_o.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/rsrc_datapath.sv
// datapath for the region shift/rotate canvas: request registers, canvas
// memory, line scan counters and result register; depends on rsrc_pkg
module rsrc_datapath #(
   parameter int CANVAS_WIDTH  = rsrc_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = rsrc_pkg::DEF_CANVAS_HEIGHT,
   parameter int PIXEL_BITS    = rsrc_pkg::DEF_PIXEL_BITS
) (
   input  logic                          clock,
   input  logic [rsrc_pkg::CMD_W-1:0]    req_cmd,
   input  logic [rsrc_pkg::POS_W-1:0]    req_pos_x,
   input  logic [rsrc_pkg::POS_W-1:0]    req_pos_y,
   input  logic [rsrc_pkg::SIZE_W-1:0]   req_rect_width,
   input  logic [rsrc_pkg::SIZE_W-1:0]   req_rect_height,
   input  logic [rsrc_pkg::DIR_W-1:0]    req_direction,
   input  logic                          req_wrap,
   input  logic [rsrc_pkg::PORT_PIX_W-1:0] req_write_pixel,
   input  rsrc_pkg::ctrl_cmd_type         cmd_i,
   output rsrc_pkg::dp_status_type        status_o,
   output logic [rsrc_pkg::PORT_PIX_W-1:0] rsp_read_pixel
);
   import rsrc_pkg::*;

   localparam int XB    = $clog2(CANVAS_WIDTH + 1);
   localparam int YB    = $clog2(CANVAS_HEIGHT + 1);
   localparam int XYB   = (XB > YB) ? XB : YB;
   localparam int GW    = (XYB > 8) ? XYB : 8;
   localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // latched request
   logic [CMD_W-1:0]      cmd_ff;
   logic [DIR_W-1:0]      dir_ff;
   logic                  wrap_ff;
   logic [PORT_PIX_W-1:0] wpix_ff;
   logic [GW-1:0]         x0_ff, y0_ff, x1_ff, y1_ff;
   logic                  inside_ff, nonempty_ff;

   // scan state
   logic [GW-1:0]         line_ff, pos_ff;
   logic [AW-1:0]         addr_d1_ff, addr_d2_ff;
   logic                  rd_first_ff;
   logic [PIXEL_BITS-1:0] temp_ff;
   logic [PIXEL_BITS-1:0] mem_q_ff;
   logic [PORT_PIX_W-1:0] rsp_pixel_ff;

   logic [PIXEL_BITS-1:0] canvas_mem [DEPTH];

   logic [GW-1:0] in_x0, in_y0, in_xsum, in_ysum, in_x1, in_y1;
   logic          vertical;
   logic [GW-1:0] line_len, line_end, sx, sy, ax, ay;
   logic [AW-1:0] cur_addr;
   logic          arrival;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   logic [PIXEL_BITS-1:0] mem_wdata;

   // clip the rectangle on the way in
   always_comb begin
      in_x0   = GW'(req_pos_x);
      in_y0   = GW'(req_pos_y);
      in_xsum = in_x0 + GW'(req_rect_width);
      in_ysum = in_y0 + GW'(req_rect_height);
      in_x1   = (in_xsum > GW'(CANVAS_WIDTH))  ? GW'(CANVAS_WIDTH)  : in_xsum;
      in_y1   = (in_ysum > GW'(CANVAS_HEIGHT)) ? GW'(CANVAS_HEIGHT) : in_ysum;
   end

   // position k along the current line, counted from the edge that leaves
   always_comb begin
      vertical = (dir_ff == DIR_UP) || (dir_ff == DIR_DOWN);
      line_len = vertical ? (y1_ff - y0_ff) : (x1_ff - x0_ff);
      line_end = vertical ? x1_ff : y1_ff;
      sx       = line_ff;
      sy       = line_ff;
      unique case (dir_ff)
         DIR_UP:    sy = y0_ff + pos_ff;
         DIR_DOWN:  sy = y1_ff - GW'(1) - pos_ff;
         DIR_LEFT:  sx = x0_ff + pos_ff;
         DIR_RIGHT: sx = x1_ff - GW'(1) - pos_ff;
         default:   sx = line_ff;
      endcase
      ax       = cmd_i.scan_step ? sx : x0_ff;
      ay       = cmd_i.scan_step ? sy : y0_ff;
      cur_addr = AW'(ay) * AW'(CANVAS_WIDTH) + AW'(ax);
   end

   // read data of the previous scan read is on mem_q_ff now
   assign arrival = (cmd_i.scan_step && (pos_ff != '0)) || cmd_i.tail;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = PIXEL_BITS'(wpix_ff);
      priority if (cmd_i.pix_write) begin
         mem_we = inside_ff;
      end else if (arrival && !rd_first_ff) begin
         mem_we    = 1'b1;
         mem_waddr = addr_d2_ff;
         mem_wdata = mem_q_ff;
      end else if (cmd_i.wrap_write) begin
         mem_we    = 1'b1;
         mem_waddr = addr_d1_ff;
         mem_wdata = temp_ff;
      end else begin
         mem_we = 1'b0;
      end
      mem_re = (cmd_i.pix_read && inside_ff) || cmd_i.scan_step;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_q_ff <= canvas_mem[cur_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         cmd_ff      <= req_cmd;
         dir_ff      <= req_direction;
         wrap_ff     <= req_wrap;
         wpix_ff     <= req_write_pixel;
         x0_ff       <= in_x0;
         y0_ff       <= in_y0;
         x1_ff       <= in_x1;
         y1_ff       <= in_y1;
         inside_ff   <= (in_x0 < GW'(CANVAS_WIDTH)) && (in_y0 < GW'(CANVAS_HEIGHT));
         nonempty_ff <= (req_rect_width != '0) && (req_rect_height != '0);
      end
      if (cmd_i.line_start) begin
         line_ff <= vertical ? x0_ff : y0_ff;
         pos_ff  <= '0;
      end else if (cmd_i.next_line) begin
         line_ff <= line_ff + GW'(1);
         pos_ff  <= '0;
      end else if (cmd_i.scan_step) begin
         pos_ff <= pos_ff + GW'(1);
      end
      if (cmd_i.scan_step) begin
         addr_d1_ff  <= cur_addr;
         addr_d2_ff  <= addr_d1_ff;
         rd_first_ff <= (pos_ff == '0);
      end
      // first pixel of a line is held for the rotate write
      if (arrival && rd_first_ff) begin
         temp_ff <= mem_q_ff;
      end
      if (cmd_i.rsp_load) begin
         rsp_pixel_ff <= (cmd_ff == CMD_READ && inside_ff) ?
                         PORT_PIX_W'(mem_q_ff) : '0;
      end
   end

   always_comb begin
      status_o.is_write   = (cmd_ff == CMD_WRITE);
      status_o.is_read    = (cmd_ff == CMD_READ);
      status_o.move_go    = (cmd_ff == CMD_MOVE) && inside_ff && nonempty_ff;
      status_o.wrap       = wrap_ff;
      status_o.line_last  = (pos_ff == line_len - GW'(1));
      status_o.lines_last = (line_ff == line_end - GW'(1));
   end

   assign rsp_read_pixel = rsp_pixel_ff;

endmodule

>>> rtl/region_shift_rotate_canvas_unit.sv
// pixel read/write, other commands and empty moves: accepted in idle, then decode, then
// the result load in finish; the result is valid after the result load and the next item
// is accepted back in idle; a move of a clipped rectangle with lines of length L (columns
// for up/down, rows for left/right) scans each line, then a tail step and, for rotate, a
// wrap write, before finish; a waiting result holds the item in its last cycle
// synchronous reset clears the controller and result valid; canvas undefined until written
module region_shift_rotate_canvas_unit #(
   parameter int CANVAS_WIDTH  = rsrc_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = rsrc_pkg::DEF_CANVAS_HEIGHT,
   parameter int PIXEL_BITS    = rsrc_pkg::DEF_PIXEL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rsrc_pkg::CMD_W-1:0]      req_cmd,
   input  logic [rsrc_pkg::POS_W-1:0]      req_pos_x,
   input  logic [rsrc_pkg::POS_W-1:0]      req_pos_y,
   input  logic [rsrc_pkg::SIZE_W-1:0]     req_rect_width,
   input  logic [rsrc_pkg::SIZE_W-1:0]     req_rect_height,
   input  logic [rsrc_pkg::DIR_W-1:0]      req_direction,
   input  logic                            req_wrap,
   input  logic [rsrc_pkg::PORT_PIX_W-1:0] req_write_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rsrc_pkg::PORT_PIX_W-1:0] rsp_read_pixel
);
   import rsrc_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   rsrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status_i  (dp_status),
      .cmd_o     (ctrl_cmd)
   );

   rsrc_datapath #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .PIXEL_BITS    (PIXEL_BITS)
   ) u_datapath (
      .clock           (clock),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_direction   (req_direction),
      .req_wrap        (req_wrap),
      .req_write_pixel (req_write_pixel),
      .cmd_i           (ctrl_cmd),
      .status_o        (dp_status),
      .rsp_read_pixel  (rsp_read_pixel)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again right after an item");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl_cmd.rsp_load))
      else $error("result valid without a result load");

   a_one_mem_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.pix_write, ctrl_cmd.pix_read, ctrl_cmd.scan_step,
                ctrl_cmd.tail, ctrl_cmd.wrap_write}))
      else $error("more than one canvas operation in a cycle");
`endif

endmodule
